### rtl/tabu_list_fifo_match_defines.svh
// assertion macros for the tabu list block
`ifndef TABU_LIST_FIFO_MATCH_DEFINES_SVH
`define TABU_LIST_FIFO_MATCH_DEFINES_SVH

`ifndef SYNTHESIS

`define TLFM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tabu list check failed");

`define TLFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tabu list check failed");

`else

`define TLFM_ASSERT_IMPL(label, clk, rst, ante, cons)

`define TLFM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/tlfm_pkg.sv
// shared types and constants for the tabu list block
`timescale 1ns / 1ps

package tlfm_pkg;

  localparam int DEF_DEPTH       = 64;
  localparam int DEF_VERTEX_BITS = 10;

  localparam int REQ_W   = 2;
  localparam int MAX_W   = 7;
  localparam int COUNT_W = 7;

  localparam logic [MAX_W-1:0] MAX_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic load;
    logic insert;
    logic clear;
    logic scan_start;
    logic scan_step;
    logic publish;
  } tlfm_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             scan_done;
  } tlfm_status_t;

endpackage

### rtl/tlfm_ctrl.sv
// controller state machine for the tabu list block
`timescale 1ns / 1ps

module tlfm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  tlfm_pkg::tlfm_status_t status,
  output tlfm_pkg::tlfm_cmd_t   cmd
);
  import tlfm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_REPLY = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_REPLY;
        case (status.req_type)
          REQ_INSERT: cmd.insert = 1'b1;
          REQ_CLEAR:  cmd.clear  = 1'b1;
          REQ_QUERY: begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (rsp_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/tlfm_datapath.sv
// pair ring, pointers, scan logic and result register for the tabu list block
`timescale 1ns / 1ps

module tlfm_datapath #(
  parameter int DEPTH       = tlfm_pkg::DEF_DEPTH,
  parameter int VERTEX_BITS = tlfm_pkg::DEF_VERTEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [tlfm_pkg::MAX_W-1:0]   cfg_wr_data,
  input  logic [tlfm_pkg::REQ_W-1:0]   req_type,
  input  logic [VERTEX_BITS-1:0]       vertex_a,
  input  logic [VERTEX_BITS-1:0]       vertex_b,
  input  tlfm_pkg::tlfm_cmd_t          cmd,
  output tlfm_pkg::tlfm_status_t       status,
  output logic                         hit,
  output logic [tlfm_pkg::COUNT_W-1:0] count
);
  import tlfm_pkg::*;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;
  localparam int PAIR_W = 2 * VERTEX_BITS;

  logic [PAIR_W-1:0]      mem [DEPTH];
  logic [MAX_W-1:0]       max_entries;
  logic [REQ_W-1:0]       req_q;
  logic [VERTEX_BITS-1:0] key_a;
  logic [VERTEX_BITS-1:0] key_b;
  logic [IDX_W-1:0]       oldest;
  logic [IDX_W-1:0]       tail;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       left;
  logic                   rd_pend;
  logic [PAIR_W-1:0]      rd_data;
  logic                   hit_acc;

  logic [WIDE_W-1:0]      max_wide;
  logic [CNT_W-1:0]       eff_max;
  logic                   evict;
  logic                   restart;
  logic [IDX_W-1:0]       wr_addr;
  logic                   rd_issue;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // clamp the configured maximum to 1..DEPTH
  always_comb begin
    max_wide = WIDE_W'(max_entries);
    if (max_wide == '0) begin
      eff_max = CNT_W'(1);
    end else if (max_wide > WIDE_W'(DEPTH)) begin
      eff_max = CNT_W'(DEPTH);
    end else begin
      eff_max = CNT_W'(max_wide);
    end
  end

  assign evict    = (cnt >= eff_max);
  assign restart  = evict && (cnt == CNT_W'(1));
  assign wr_addr  = restart ? '0 : tail;
  assign rd_issue = cmd.scan_step && (left != '0);

  assign status.req_type  = req_q;
  assign status.scan_done = (left == '0) && !rd_pend;

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem[wr_addr] <= {key_a, key_b};
    end
    if (rd_issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_RESET;
      oldest      <= '0;
      tail        <= '0;
      cnt         <= '0;
      left        <= '0;
      rd_pend     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_entries <= cfg_wr_data;
      end
      if (cmd.clear) begin
        oldest <= '0;
        tail   <= '0;
        cnt    <= '0;
      end else if (cmd.insert) begin
        tail <= ring_inc(wr_addr);
        if (evict) begin
          oldest <= restart ? '0 : ring_inc(oldest);
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.scan_start) begin
        left    <= cnt;
        rd_pend <= 1'b0;
      end else if (cmd.scan_step) begin
        if (rd_issue) begin
          left <= left - 1'b1;
        end
        rd_pend <= rd_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      key_a <= vertex_a;
      key_b <= vertex_b;
    end
    if (cmd.scan_start) begin
      rd_ptr  <= oldest;
      hit_acc <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_issue) begin
        rd_ptr <= ring_inc(rd_ptr);
      end
      if (rd_pend && (rd_data == {key_a, key_b})) begin
        hit_acc <= 1'b1;
      end
    end
    if (cmd.publish) begin
      hit   <= (req_q == REQ_QUERY) && hit_acc;
      count <= COUNT_W'(cnt);
    end
  end

endmodule

### rtl/tabu_list_fifo_match.sv
// Top level of the tabu list: a bounded oldest-first list of ordered vertex
// pairs in a ring of DEPTH entries. One word in gives one word out with the
// hit flag and the count held afterwards. The block takes one word at a time.
// Every word passes an execute state and a reply state; a query adds a scan
// state that walks the live entries through the single read port of the pair
// memory, one entry a cycle. The next word is taken once the result has moved
// into the output register. The pair memory needs no clearing after reset.
`timescale 1ns / 1ps
`include "tabu_list_fifo_match_defines.svh"

module tabu_list_fifo_match #(
  parameter int DEPTH       = tlfm_pkg::DEF_DEPTH,
  parameter int VERTEX_BITS = tlfm_pkg::DEF_VERTEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [tlfm_pkg::MAX_W-1:0]   cfg_wr_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [tlfm_pkg::REQ_W-1:0]   req_type,
  input  logic [VERTEX_BITS-1:0]       vertex_a,
  input  logic [VERTEX_BITS-1:0]       vertex_b,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         hit,
  output logic [tlfm_pkg::COUNT_W-1:0] count
);
  import tlfm_pkg::*;

  tlfm_cmd_t    cmd;
  tlfm_status_t status;

  tlfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlfm_datapath #(
    .DEPTH       (DEPTH),
    .VERTEX_BITS (VERTEX_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req_type),
    .vertex_a    (vertex_a),
    .vertex_b    (vertex_b),
    .cmd         (cmd),
    .status      (status),
    .hit         (hit),
    .count       (count)
  );

  `TLFM_ASSERT_NEXT(a_one_word_at_a_time, clk, rst, req_valid && !req_stall, req_stall)
  `TLFM_ASSERT_NEXT(a_publish_shows_word, clk, rst, cmd.publish, rsp_valid)
  `TLFM_ASSERT_IMPL(a_hit_needs_entries, clk, rst, rsp_valid && hit, count != '0)

endmodule

### test/tb_tabu_list_fifo_match.sv
// testbench for the tabu list block: directed and random requests checked against a local list model
`timescale 1ns / 1ps

module tb_tabu_list_fifo_match;
  import tlfm_pkg::*;

  localparam int RING = DEF_DEPTH;
  localparam int VB = DEF_VERTEX_BITS;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = RING + 20;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [VB-1:0]    a;
    logic [VB-1:0]    b;
  } tabu_req_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
  } tabu_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [MAX_W-1:0]   cfg_wr_data = '0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [REQ_W-1:0]   req_type = '0;
  logic [VB-1:0]      vertex_a = '0;
  logic [VB-1:0]      vertex_b = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic               hit;
  logic [COUNT_W-1:0] count;

  tabu_list_fifo_match dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .vertex_a    (vertex_a),
    .vertex_b    (vertex_b),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .count       (count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // list model
  logic [VB-1:0]    list_a [RING];
  logic [VB-1:0]    list_b [RING];
  int unsigned      list_head = 0;
  int unsigned      list_len = 0;
  logic [MAX_W-1:0] max_pairs = MAX_RESET;

  tabu_req_t pending_reqs[$];
  tabu_rsp_t expected_rsps[$];
  tabu_req_t recent_pairs[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit pressure_on = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_by_kind [4] = '{default: 0};
  int n_results = 0;
  int n_hits = 0;
  int peak_count = 0;
  int n_errors = 0;

  function automatic tabu_rsp_t apply_request(tabu_req_t r);
    int unsigned limit;
    tabu_rsp_t   rsp;
    rsp.hit = 1'b0;
    limit = (max_pairs == 0) ? 1 : ((max_pairs > RING) ? RING : max_pairs);
    case (r.kind)
      REQ_INSERT: begin
        if (list_len >= limit && list_len > 0) begin
          list_head = (list_head + 1) % RING;
          list_len--;
          if (list_len == 0) list_head = 0;
        end
        if (list_len < RING) begin
          list_a[(list_head + list_len) % RING] = r.a;
          list_b[(list_head + list_len) % RING] = r.b;
          list_len++;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < list_len; i++)
          if (list_a[(list_head + i) % RING] == r.a && list_b[(list_head + i) % RING] == r.b)
            rsp.hit = 1'b1;
      end
      REQ_CLEAR: begin
        list_len = 0;
        list_head = 0;
      end
      default: ;
    endcase
    rsp.count = COUNT_W'(list_len);
    return rsp;
  endfunction

  // half the vertices from a small pool so that pairs repeat
  function automatic logic [VB-1:0] pick_vertex();
    return ($urandom_range(1) == 1) ? VB'($urandom_range(7)) : VB'($urandom_range((1 << VB) - 1));
  endfunction

  function automatic tabu_req_t random_request(int clear_pct);
    tabu_req_t r;
    tabu_req_t old;
    int        roll;
    roll = $urandom_range(99);
    r.a = pick_vertex();
    r.b = pick_vertex();
    if (roll < clear_pct) begin
      r.kind = REQ_CLEAR;
      recent_pairs.delete();
    end else if (roll < clear_pct + 3) begin
      r.kind = REQ_UNUSED;
    end else if (roll < clear_pct + 50) begin
      r.kind = REQ_INSERT;
      recent_pairs.push_back(r);
      if (recent_pairs.size() > RING) void'(recent_pairs.pop_front());
    end else begin
      r.kind = REQ_QUERY;
      if (recent_pairs.size() > 0 && $urandom_range(99) < 70) begin
        old = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
        r.a = old.a;
        r.b = old.b;
        // swapped order must miss unless the reverse pair is also held
        if ($urandom_range(6) == 0) begin
          r.a = old.b;
          r.b = old.a;
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_req(logic [REQ_W-1:0] k, logic [VB-1:0] a, logic [VB-1:0] b);
    pending_reqs.push_back({k, a, b});
  endfunction

  task automatic queue_random(int n, int clear_pct);
    repeat (n) pending_reqs.push_back(random_request(clear_pct));
  endtask

  // sampled away from the rising edge so the driver and monitor have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
  endtask

  task automatic set_max(input logic [MAX_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_pairs = v;
  endtask

  always @(posedge clk) begin : drive_proc
    tabu_req_t next_req;
    logic      next_valid;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      next_valid = req_valid;
      next_req = {req_type, vertex_a, vertex_b};
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(apply_request(next_req));
        n_by_kind[req_type]++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_reqs.pop_front();
        next_valid = 1'b1;
      end
      req_valid <= next_valid;
      req_type <= next_req.kind;
      vertex_a <= next_req.a;
      vertex_b <= next_req.b;
    end
  end

  always @(posedge clk) begin : check_proc
    tabu_rsp_t want;
    logic      stall_next;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_results++;
        if (hit) n_hits++;
        if (count > peak_count) peak_count = count;
        if (expected_rsps.size() == 0) begin
          n_errors++;
          $display("%0t: word with nothing expected, hit %0b count %0d", $time, hit, count);
        end else begin
          want = expected_rsps.pop_front();
          if (hit !== want.hit) begin
            n_errors++;
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, hit);
          end
          if (count !== want.count) begin
            n_errors++;
            $display("%0t: count expected %0d, got %0d", $time, want.count, count);
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (pressure_on && !pressure_done) begin
        hold_left = HOLD_OFF_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(99) < receiver_stall_pct);
      end
      rsp_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[tabu_list_fifo_match] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list, corner vertices, ordered match, unused code
    queue_req(REQ_CLEAR, 10'd0, 10'd0);
    queue_req(REQ_QUERY, 10'd0, 10'd0);
    queue_req(REQ_INSERT, 10'd0, 10'd0);
    queue_req(REQ_INSERT, 10'd1023, 10'd1023);
    queue_req(REQ_INSERT, 10'd1023, 10'd0);
    queue_req(REQ_QUERY, 10'd0, 10'd1023);
    queue_req(REQ_QUERY, 10'd1023, 10'd0);
    queue_req(REQ_QUERY, 10'd1023, 10'd1023);
    queue_req(REQ_UNUSED, 10'd1023, 10'd1023);
    queue_req(REQ_INSERT, 10'h2aa, 10'h155);
    queue_req(REQ_QUERY, 10'h2aa, 10'h155);
    queue_req(REQ_QUERY, 10'h155, 10'h2aa);
    queue_req(REQ_CLEAR, 10'd0, 10'd0);
    queue_req(REQ_QUERY, 10'd0, 10'd0);
    queue_req(REQ_CLEAR, 10'd0, 10'd0);
    wait_idle();

    // zero maximum behaves as one
    set_max(7'd0);
    queue_req(REQ_INSERT, 10'd5, 10'd6);
    queue_req(REQ_INSERT, 10'd7, 10'd8);
    queue_req(REQ_QUERY, 10'd5, 10'd6);
    queue_req(REQ_QUERY, 10'd7, 10'd8);
    wait_idle();

    set_max(7'd64);
    queue_random(140, 0);
    wait_idle();

    // above ring size
    sender_idle_pct = 45;
    set_max(7'd127);
    queue_random(140, 0);
    wait_idle();

    // lowered below the held count
    sender_idle_pct = 0;
    receiver_stall_pct = 45;
    set_max(7'd5);
    queue_random(120, 3);
    wait_idle();

    sender_idle_pct = 26;
    receiver_stall_pct = 26;
    set_max(7'd1);
    queue_random(80, 2);
    wait_idle();

    set_max(7'd2);
    queue_random(60, 2);
    wait_idle();

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_max(7'd64);
    queue_random(60, 0);
    wait_idle();

    sender_idle_pct = 26;
    receiver_stall_pct = 26;
    set_max(7'd3);
    queue_random(100, 0);
    wait_idle();

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_max(7'd16);
    pressure_on = 1'b1;
    queue_random(80, 4);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("requests sent: %0d insert, %0d query, %0d clear, %0d unused code",
             n_by_kind[REQ_INSERT], n_by_kind[REQ_QUERY], n_by_kind[REQ_CLEAR],
             n_by_kind[REQ_UNUSED]);
    $display("words checked: %0d, hits %0d, peak count %0d, mismatches %0d",
             n_results, n_hits, peak_count, n_errors);
    if (n_errors == 0) begin
      $display("[tabu_list_fifo_match] OK");
    end else begin
      $display("[tabu_list_fifo_match] ERROR");
    end
    $finish;
  end

endmodule
